// ----- rtl/core/bptc_pkg.sv -----
`timescale 1ns / 1ps
package bptc_pkg;
    localparam int unsigned WordW = 32;
    localparam int unsigned RawW = 24;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] REG_TEMP = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PRES = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_CURV = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_OFFS = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SENS = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_LIN = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_MODE = 3'd6;

    localparam logic [1:0] MODE_LEGACY = 2'd0;
    localparam logic [1:0] MODE_NEW = 2'd1;
    localparam logic [1:0] MODE_V3 = 2'd2;

    typedef logic [WordW-1:0] word_t;

    // Full 32-bit wrapping multiply; both operands are used as bit patterns.
    function automatic word_t mul32(input word_t a, input word_t b);
        logic [2*WordW-1:0] p;
        p = a * b;
        return p[WordW-1:0];
    endfunction

    function automatic word_t asr(input word_t x, input int unsigned s);
        return word_t'($signed(x) >>> s);
    endfunction

    function automatic logic sge(input word_t a, input word_t b);
        return $signed(a) >= $signed(b);
    endfunction
endpackage

// ----- rtl/core/bptc_if.sv -----
`timescale 1ns / 1ps
interface bptc_in_if;
    logic valid;
    logic ready;
    logic [23:0] raw_temperature;
    logic [23:0] raw_pressure;
    modport source (output valid, raw_temperature, raw_pressure, input ready);
    modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bptc_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] temperature_centideg;
    logic signed [31:0] pressure_pascal;
    modport source (output valid, temperature_centideg, pressure_pascal, input ready);
    modport sink (input valid, temperature_centideg, pressure_pascal, output ready);
endinterface

// ----- rtl/core/baro_pressure_temp_compensation.sv -----
`timescale 1ns / 1ps
// Barometric compensation pipeline.
// Input channel in_ch carries one raw temperature and raw pressure per beat;
// output channel out_ch carries the compensated temperature (0.01 C) and
// pressure (Pa). Calibration is to be written by the user, through
// cfg_we/cfg_idx/cfg_data, while the pipeline is empty; the block does not
// enforce this. Register i of the calibration map is index i. Throughput is
// one beat per cycle unless the receiver stalls: fifteen register stages
// advance together, and no path inside a stage runs through more than one
// 32-bit multiply. When the receiver stalls, the whole pipeline holds;
// in_ch.ready is high whenever the output register is free or being taken,
// so no beat is lost. Reset clears all valid bits and returns calibration
// to its reset values (all coefficients zero, formula mode 1).
module baro_pressure_temp_compensation
    import bptc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_idx,
    input  logic [CfgDataW-1:0] cfg_data,
    bptc_in_if.sink             in_ch,
    bptc_out_if.source          out_ch
);
    localparam int unsigned NSt = 15;

    typedef struct packed {
        word_t dt, a1, a2, a3, x, y, dt2, rt;
        word_t o1, off, g1, g2, k, hi, lo, gain;
        word_t q1, q2, q3, q4, cf, n1, n2, rp;
        word_t slope, drt, corr;
        word_t p;
    } st_t;

    logic [63:0] tc_reg, pc_reg;
    word_t curv_reg, c4_reg, c5_reg, c7_reg;
    logic [1:0] mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg <= '0; pc_reg <= '0; curv_reg <= '0;
            c4_reg <= '0; c5_reg <= '0; c7_reg <= '0; mode_reg <= MODE_NEW;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_TEMP: tc_reg <= cfg_data;
                REG_PRES: pc_reg <= cfg_data;
                REG_CURV: curv_reg <= cfg_data[31:0];
                REG_OFFS: c4_reg <= cfg_data[31:0];
                REG_SENS: c5_reg <= cfg_data[31:0];
                REG_LIN:  c7_reg <= cfg_data[31:0];
                REG_MODE: mode_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    word_t c0, c1, c2, c3, c6, c8, c9, c10, c11, c12;
    logic legacy, v3;
    assign c0 = {16'd0, tc_reg[15:0]};
    assign c1 = {16'd0, tc_reg[31:16]};
    assign c2 = {16'd0, tc_reg[47:32]};
    assign c3 = {16'd0, tc_reg[63:48]};
    assign c6 = {16'd0, pc_reg[15:0]};
    assign c8 = {16'd0, pc_reg[31:16]};
    assign c9 = {16'd0, pc_reg[47:32]};
    assign c10 = {16'd0, pc_reg[63:48]};
    assign c11 = {16'd0, curv_reg[15:0]};
    assign c12 = {16'd0, curv_reg[31:16]};
    assign legacy = (mode_reg == MODE_LEGACY);
    assign v3 = (mode_reg == MODE_V3);

    st_t st_reg [NSt];
    st_t st_next [NSt];
    logic [NSt-1:0] vld_reg;
    logic adv;

    assign adv = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;

    always_comb
    begin
        st_t s;
        word_t d, sp;
        for (int i = 0; i < NSt; i++) st_next[i] = '0;

        // Stage 0: temperature delta and raw pressure.
        s = '0;
        s.dt = asr({8'd0, in_ch.raw_temperature} - 32'd8388608, 4) + (c0 << 4);
        s.p = {8'd0, in_ch.raw_pressure};
        st_next[0] = s;

        s = st_reg[0];
        s.a1 = asr(mul32(c1 + 32'd4459, s.dt), 1);
        s.x = asr(mul32(c2 - 32'd256, s.dt), 14);
        s.y = asr(mul32(c3, s.dt), 18);
        st_next[1] = s;

        s = st_reg[1];
        s.a2 = asr(mul32(s.x, s.dt), 4);
        s.y = asr(mul32(s.y, s.dt), 18);
        st_next[2] = s;

        s = st_reg[2];
        s.a3 = mul32(s.y, s.dt);
        st_next[3] = s;

        s = st_reg[3];
        s.rt = asr(32'd81920000 - s.a1 - s.a2 - s.a3, 15);
        s.dt2 = asr(s.a1 + s.a2 + s.a3, 12);
        st_next[4] = s;

        s = st_reg[4];
        s.o1 = mul32(c5_reg - 32'd4443, s.dt2);
        s.x = asr(mul32(c6, s.dt2), 16);
        s.g1 = asr(mul32(c8 + 32'd7180, s.dt2), 10);
        s.y = asr(mul32(c9, s.dt2), 17);
        st_next[5] = s;

        s = st_reg[5];
        s.off = asr(s.o1 + asr(mul32(s.x, s.dt2), 2), 10) + ((c4_reg + 32'd120586) << 4);
        s.g2 = asr(mul32(s.y, s.dt2), 12);
        s.cf = asr(32'd2097152 + mul32(c12, s.dt2), 3);
        st_next[6] = s;

        s = st_reg[6];
        d = s.g2 - s.g1;
        if (legacy)
            sp = sge(s.g2, s.g1) ? d : (s.g1 - s.g2);
        else
            sp = d[31] ? (32'd0 - d) : d;
        s.k = c7_reg + 32'd166426;
        s.hi = mul32(asr(sp, 11), s.k);
        s.lo = mul32({21'd0, sp[10:0]}, s.k) >> 11;
        s.q1 = asr((s.p - 32'd8388608) - s.off, 3);
        s.x = asr(mul32(s.cf, c10), 17);
        s.y = asr(mul32(s.cf, c11), 15);
        st_next[7] = s;

        s = st_reg[7];
        if (sge(s.g1, s.g2))
            s.gain = asr(32'd0 - s.hi - s.lo, 11) + s.k;
        else
            s.gain = asr(s.hi + s.lo, 11) + s.k;
        st_next[8] = s;

        s = st_reg[8];
        s.q2 = mul32(asr(s.gain, 11), s.q1);
        s.q3 = asr(mul32({21'd0, s.gain[10:0]}, s.q1), 11);
        st_next[9] = s;

        s = st_reg[9];
        s.q4 = asr(s.q2 + s.q3, 10);
        s.drt = s.rt - 32'd2500;
        s.slope = asr(asr(mul32(32'd549, c5_reg - 32'd16384), 9) + 32'd559, 4);
        st_next[10] = s;

        s = st_reg[10];
        s.n1 = asr(mul32(s.x, s.q4), 2);
        s.y = asr(mul32(s.y, s.q4), 18);
        s.slope = asr(mul32(s.slope, s.drt), 15);
        st_next[11] = s;

        s = st_reg[11];
        s.n2 = mul32(s.y, s.q4);
        s.corr = asr(mul32(s.slope, s.drt), 11);
        s.x = asr(mul32(s.rt, 32'd0 - 32'd1513), 16) + 32'd46;
        s.y = asr(mul32(s.rt, 32'd819), 16) - 32'd9;
        st_next[12] = s;

        s = st_reg[12];
        s.rp = asr(s.n1 + s.n2, 15) + s.q4 + (legacy ? 32'd99880 : 32'd100000);
        st_next[13] = s;

        s = st_reg[13];
        if (v3)
        begin
            s.rp = s.rp - s.corr;
            if (!sge(s.rt, 32'd2000))
            begin
                if (!sge(s.rt, 32'd700))
                    s.rp = s.rp - (s.y + s.x);
                else
                    s.rp = s.rp - s.x;
            end
        end
        st_next[14] = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSt-2:0], in_ch.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NSt; i++) st_reg[i] <= st_next[i];
        end
    end

    assign out_ch.valid = vld_reg[NSt-1];
    assign out_ch.temperature_centideg = st_reg[NSt-1].rt;
    assign out_ch.pressure_pascal = st_reg[NSt-1].rp;
endmodule

// ----- rtl/core/bptc_checker.sv -----
`timescale 1ns / 1ps
module bptc_checker
    import bptc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [31:0] out_t,
    input logic [31:0] out_p
);
    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_t) && $stable(out_p))
        else $error("stalled result changed");

    // Input side is ready whenever the output register is free.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Ready follows the receiver while a result waits.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during stall");
endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_t(out_ch.temperature_centideg), .out_p(out_ch.pressure_pascal)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import bptc_pkg::*;

    typedef struct packed {
        logic [31:0] temperature_centideg;
        logic [31:0] pressure_pascal;
    } comp_result_t;

    typedef struct {
        logic [23:0] t_raw;
        logic [23:0] p_raw;
        bit          known;
        logic [31:0] t_exp;
        logic [31:0] p_exp;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CfgIdxW-1:0] cfg_idx;
    logic [CfgDataW-1:0] cfg_data;

    bptc_in_if in_ch();
    bptc_out_if out_ch();

    baro_pressure_temp_compensation uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_data(cfg_data),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    // Calibration shadow used by the predictor.
    logic [63:0] cal_temp;
    logic [63:0] cal_pres;
    logic [31:0] cal_curv;
    logic [31:0] cal_c4;
    logic [31:0] cal_c5;
    logic [31:0] cal_c7;
    logic [1:0]  cal_mode;

    comp_result_t pending_results[$];
    int errors;
    bit stall_hold;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [31:0] sra(input logic [31:0] x, input int s);
        return $signed(x) >>> s;
    endfunction

    function automatic logic [31:0] m32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p[31:0];
    endfunction

    function automatic comp_result_t compensate(input logic [23:0] t_raw,
                                                input logic [23:0] p_raw);
        logic [31:0] t, p, c0, c1, c2, c3, c6, c8, c9, c10, c11, c12;
        logic [31:0] dt, a1, a2, a3, rt, dt2, o1, o2, off, g1, g2, spread, d;
        logic [31:0] k, hi, lo, gain, q1, q2, q3, q4, cf, n1, n2, rp;
        logic [31:0] dc5, drt, slope, corr;
        bit legacy;
        comp_result_t r;
        t = {8'd0, t_raw};
        p = {8'd0, p_raw};
        c0 = {16'd0, cal_temp[15:0]};
        c1 = {16'd0, cal_temp[31:16]};
        c2 = {16'd0, cal_temp[47:32]};
        c3 = {16'd0, cal_temp[63:48]};
        c6 = {16'd0, cal_pres[15:0]};
        c8 = {16'd0, cal_pres[31:16]};
        c9 = {16'd0, cal_pres[47:32]};
        c10 = {16'd0, cal_pres[63:48]};
        c11 = {16'd0, cal_curv[15:0]};
        c12 = {16'd0, cal_curv[31:16]};
        legacy = (cal_mode == MODE_LEGACY);

        dt = sra(t - 32'd8388608, 4) + (c0 << 4);
        a1 = sra(m32(c1 + 32'd4459, dt), 1);
        a2 = sra(m32(sra(m32(c2 - 32'd256, dt), 14), dt), 4);
        a3 = m32(sra(m32(sra(m32(c3, dt), 18), dt), 18), dt);
        rt = sra(32'd81920000 - a1 - a2 - a3, 15);
        dt2 = sra(a1 + a2 + a3, 12);

        o1 = m32(cal_c5 - 32'd4443, dt2);
        o2 = sra(m32(sra(m32(c6, dt2), 16), dt2), 2);
        off = sra(o1 + o2, 10) + ((cal_c4 + 32'd120586) << 4);

        g1 = sra(m32(c8 + 32'd7180, dt2), 10);
        g2 = sra(m32(sra(m32(c9, dt2), 17), dt2), 12);
        if (legacy)
            spread = ($signed(g2) >= $signed(g1)) ? g2 - g1 : g1 - g2;
        else
        begin
            d = g2 - g1;
            spread = d[31] ? 32'd0 - d : d;
        end
        k = cal_c7 + 32'd166426;
        hi = m32(sra(spread, 11), k);
        lo = m32(spread & 32'h7FF, k) >> 11;
        if ($signed(g1) >= $signed(g2))
            gain = sra(32'd0 - hi - lo, 11) + k;
        else
            gain = sra(hi + lo, 11) + k;

        q1 = sra((p - 32'd8388608) - off, 3);
        q2 = m32(sra(gain, 11), q1);
        q3 = sra(m32(gain & 32'h7FF, q1), 11);
        q4 = sra(q2 + q3, 10);

        cf = sra(32'd2097152 + m32(c12, dt2), 3);
        n1 = sra(m32(sra(m32(cf, c10), 17), q4), 2);
        n2 = m32(sra(m32(sra(m32(cf, c11), 15), q4), 18), q4);
        rp = sra(n1 + n2, 15) + q4 + (legacy ? 32'd99880 : 32'd100000);

        if (cal_mode == MODE_V3)
        begin
            dc5 = cal_c5 - 32'd16384;
            drt = rt - 32'd2500;
            slope = sra(sra(m32(32'd549, dc5), 9) + 32'd559, 4);
            corr = sra(m32(sra(m32(slope, drt), 15), drt), 11);
            rp = rp - corr;
            if ($signed(rt) < $signed(32'd2000))
            begin
                corr = sra(m32(rt, 32'd0 - 32'd1513), 16) + 32'd46;
                if ($signed(rt) < $signed(32'd700))
                    corr = sra(m32(rt, 32'd819), 16) - 32'd9 + corr;
                rp = rp - corr;
            end
        end
        r.temperature_centideg = rt;
        r.pressure_pascal = rp;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got %0d expected %0d", $realtime, what,
                 $signed(got), $signed(want));
        errors++;
    endtask

    // The enable drops for one cycle after each write, so back-to-back calls
    // never schedule two updates of it at the same edge.
    task automatic write_cal(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TEMP: cal_temp = val;
            REG_PRES: cal_pres = val;
            REG_CURV: cal_curv = val[31:0];
            REG_OFFS: cal_c4 = val[31:0];
            REG_SENS: cal_c5 = val[31:0];
            REG_LIN:  cal_c7 = val[31:0];
            REG_MODE: cal_mode = val[1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Sends one beat; the valid stays high while the caller keeps sending.
    task automatic send_beat(input logic [23:0] t_raw, input logic [23:0] p_raw);
        in_ch.valid <= 1'b1;
        in_ch.raw_temperature <= t_raw;
        in_ch.raw_pressure <= p_raw;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_results.push_back(compensate(t_raw, p_raw));
    endtask

    task automatic idle_cycles(input int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Realistic calibration words keep the polynomials near their working range; wild ones are fully random.
    task automatic program_random_cal(input logic [1:0] mode, input bit wild);
        if (wild)
        begin
            write_cal(REG_TEMP, rand64());
            write_cal(REG_PRES, rand64());
            write_cal(REG_CURV, 64'($urandom()));
            write_cal(REG_OFFS, 64'($urandom()));
            write_cal(REG_SENS, 64'($urandom()));
            write_cal(REG_LIN, 64'($urandom()));
        end
        else
        begin
            write_cal(REG_TEMP, {16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)),
                                 16'($urandom_range(0, 600)), 16'($urandom_range(0, 2000))});
            write_cal(REG_PRES, {16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)),
                                 16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000))});
            write_cal(REG_CURV, {32'd0, 16'($urandom_range(0, 4000)),
                                 16'($urandom_range(0, 4000))});
            write_cal(REG_OFFS, 64'($urandom_range(0, 40000)));
            write_cal(REG_SENS, 64'($urandom_range(0, 40000)));
            write_cal(REG_LIN, 64'($urandom_range(0, 40000)));
        end
        write_cal(REG_MODE, {62'd0, mode});
    endtask

    // Receiver: random stall pattern, plus a long hold-off when requested.
    initial
    begin
        int run;
        int hold;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (stall_hold)
            begin
                out_ch.ready <= 1'b0;
                for (hold = 0; hold < 200; hold++)
                    @(posedge clk);
                stall_hold = 1'b0;
            end
            run = $urandom_range(1, 30);
            case ($urandom_range(0, 2))
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= 1'b0;
                default: out_ch.ready <= 1'($urandom_range(0, 1));
            endcase
            repeat (run) @(posedge clk);
        end
    end

    // Output checker.
    always @(posedge clk)
    begin
        comp_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected output beat", $realtime);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.temperature_centideg !== want.temperature_centideg)
                    report_mismatch("temperature", out_ch.temperature_centideg,
                                    want.temperature_centideg);
                if (out_ch.pressure_pascal !== want.pressure_pascal)
                    report_mismatch("pressure", out_ch.pressure_pascal,
                                    want.pressure_pascal);
            end
        end
    end

    dir_row_t dir_rows[$];

    initial
    begin
        dir_row_t row;
        comp_result_t got;
        int n;
        int burst;
        int phase;
        logic [1:0] mode;
        errors = 0;
        stall_hold = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.raw_temperature = '0;
        in_ch.raw_pressure = '0;
        cal_temp = '0;
        cal_pres = '0;
        cal_curv = '0;
        cal_c4 = '0;
        cal_c5 = '0;
        cal_c7 = '0;
        cal_mode = MODE_NEW;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With all coefficients zero and the temperature at its midpoint,
        // dt is zero, so the temperature is 81920000 >> 15.
        dir_rows.push_back('{24'h800000, 24'h800000, 1'b1, 32'd2500,
                             32'hxxxxxxxx});
        dir_rows.push_back('{24'h000000, 24'h000000, 1'b0, 32'd0, 32'd0});
        dir_rows.push_back('{24'hFFFFFF, 24'hFFFFFF, 1'b0, 32'd0, 32'd0});
        dir_rows.push_back('{24'h000000, 24'hFFFFFF, 1'b0, 32'd0, 32'd0});
        dir_rows.push_back('{24'hFFFFFF, 24'h000000, 1'b0, 32'd0, 32'd0});
        dir_rows.push_back('{24'h7FFFFF, 24'h800000, 1'b0, 32'd0, 32'd0});
        dir_rows.push_back('{24'hAAAAAA, 24'h555555, 1'b0, 32'd0, 32'd0});
        dir_rows.push_back('{24'h555555, 24'hAAAAAA, 1'b0, 32'd0, 32'd0});

        // Directed: each mode (including the unused code), zero, full and random realistic calibration.
        for (phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                write_cal(REG_TEMP, '1);
                write_cal(REG_PRES, '1);
                write_cal(REG_CURV, '1);
                write_cal(REG_OFFS, '1);
                write_cal(REG_SENS, '1);
                write_cal(REG_LIN, '1);
            end
            else if (phase == 2)
                program_random_cal(MODE_LEGACY, 1'b0);
            for (int m = 0; m < 4; m++)
            begin
                if (!(phase == 0 && m == 0))
                    write_cal(REG_MODE, 64'(m));
                foreach (dir_rows[i])
                begin
                    row = dir_rows[i];
                    if (row.known && phase == 0 && m == 0)
                    begin
                        // Pressure is left to the predictor; temperature read off directly.
                        got = compensate(row.t_raw, row.p_raw);
                        if (got.temperature_centideg !== row.t_exp)
                            report_mismatch("directed temperature",
                                            got.temperature_centideg, row.t_exp);
                    end
                    if (phase < 2 || i < 3)
                        send_beat(row.t_raw, row.p_raw);
                end
                idle_cycles(1);
                wait_drain();
            end
        end

        // Random phases: mostly realistic calibration, sometimes wild.
        for (phase = 0; phase < 12; phase++)
        begin
            mode = (phase % 4 == 3) ? 2'd3 : 2'(phase % 3);
            program_random_cal(mode, phase % 5 == 4);
            if (phase == 5)
                stall_hold = 1'b1;
            n = 0;
            while (n < 155)
            begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst && n < 155; b++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_beat(24'($urandom()), 24'($urandom()));
                    else
                        send_beat(24'h800000 + 24'($urandom_range(0, 400000)) - 24'd200000,
                                  24'($urandom_range(0, 24'hFFFFFF)));
                    n++;
                end
                if (phase != 5 && $urandom_range(0, 2) != 0)
                    idle_cycles($urandom_range(1, 12));
            end
            idle_cycles(1);
            wait_drain();
        end

        wait_drain();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
